// ===== rtl/core/ecm_cnf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecm_cnf_pkg: shared definitions for the ecm class nano filter
// Register map codes, message constants, verdict codes and the
// structs that pass configuration and match results between modules.
// ----------------------------------------------------------------------------
package ecm_cnf_pkg;

	localparam int MAX_CLASSES = 8;

	// register indexes (byte address is 8 * index)
	localparam logic [1:0] REG_BLOCKED_CLASSES = 2'd0;
	localparam logic [1:0] REG_BLOCKED_COUNT   = 2'd1;
	localparam logic [1:0] REG_ALLOWED_CLASSES = 2'd2;
	localparam logic [1:0] REG_ALLOWED_COUNT   = 2'd3;

	localparam logic [7:0]  TAG_CLASS     = 8'hE2;
	localparam logic [7:0]  TAG_END       = 8'hEA;
	localparam logic [7:0]  LONG_MARK     = 8'hD2;
	localparam logic [15:0] CAID_FILTERED = 16'h0500;
	localparam logic [3:0]  START_LONG    = 4'd12;
	localparam logic [3:0]  START_SHORT   = 4'd9;
	localparam logic [3:0]  POS_LONG_MARK = 4'd4;
	localparam logic [3:0]  POS_MAX       = 4'd13;
	localparam logic [7:0]  COUNT_MAX     = 8'hFF;

	localparam logic [1:0] VERDICT_UNCHECKED   = 2'd0;
	localparam logic [1:0] VERDICT_PASS        = 2'd1;
	localparam logic [1:0] VERDICT_BLOCKED     = 2'd2;
	localparam logic [1:0] VERDICT_NOT_ALLOWED = 2'd3;

	typedef struct packed {
		logic [63:0] blocked_classes;
		logic [3:0]  blocked_count;
		logic [63:0] allowed_classes;
		logic [3:0]  allowed_count;
	} cfg_t;

	typedef struct packed {
		logic blocked;
		logic allowed;
	} match_t;

endpackage
`default_nettype wire

// ===== rtl/core/ecm_cnf_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecm_cnf_regs: configuration registers
// APB-style register file holding the blocked and allowed class lists
// and their entry counts.
// ----------------------------------------------------------------------------
module ecm_cnf_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [63:0]         pwdata,
	output logic [63:0]              prdata,
	output logic                     pready,
	output ecm_cnf_pkg::cfg_t        cfg
);

	logic [1:0] index;
	logic       wr_en;
	ecm_cnf_pkg::cfg_t cfg_q;

	assign index  = paddr[4:3];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (index)
				ecm_cnf_pkg::REG_BLOCKED_CLASSES: cfg_q.blocked_classes <= pwdata;
				ecm_cnf_pkg::REG_BLOCKED_COUNT:   cfg_q.blocked_count   <= pwdata[3:0];
				ecm_cnf_pkg::REG_ALLOWED_CLASSES: cfg_q.allowed_classes <= pwdata;
				ecm_cnf_pkg::REG_ALLOWED_COUNT:   cfg_q.allowed_count   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (index)
			ecm_cnf_pkg::REG_BLOCKED_CLASSES: prdata = cfg_q.blocked_classes;
			ecm_cnf_pkg::REG_BLOCKED_COUNT:   prdata = {60'd0, cfg_q.blocked_count};
			ecm_cnf_pkg::REG_ALLOWED_CLASSES: prdata = cfg_q.allowed_classes;
			ecm_cnf_pkg::REG_ALLOWED_COUNT:   prdata = {60'd0, cfg_q.allowed_count};
			default:                          prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/ecm_cnf_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecm_cnf_match: class list comparator
// Compares one class byte against the blocked and allowed lists in
// parallel, honoring the clamped entry counts.
// ----------------------------------------------------------------------------
module ecm_cnf_match #(
	parameter int MAX_CLASSES = ecm_cnf_pkg::MAX_CLASSES
) (
	input  wire logic [7:0]          class_byte,
	input  wire ecm_cnf_pkg::cfg_t   cfg,
	output ecm_cnf_pkg::match_t      hit
);

	localparam logic [3:0] MaxCount = 4'(MAX_CLASSES);

	logic [3:0]             nb;
	logic [3:0]             na;
	logic [MAX_CLASSES-1:0] blocked_hit;
	logic [MAX_CLASSES-1:0] allowed_hit;

	// counts above the list size act as a full list
	assign nb = (cfg.blocked_count > MaxCount) ? MaxCount : cfg.blocked_count;
	assign na = (cfg.allowed_count > MaxCount) ? MaxCount : cfg.allowed_count;

	for (genvar k = 0; k < MAX_CLASSES; k++) begin : g_entry
		assign blocked_hit[k] = (4'(k) < nb) &&
			(cfg.blocked_classes[8*k +: 8] == class_byte);
		assign allowed_hit[k] = (4'(k) < na) &&
			(cfg.allowed_classes[8*k +: 8] == class_byte);
	end

	assign hit.blocked = |blocked_hit;
	assign hit.allowed = |allowed_hit;

endmodule
`default_nettype wire

// ===== rtl/core/ecm_cnf_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecm_cnf_core: message parser and verdict stage
// Input register, per-message parse state, class matching and the
// result register with its valid/stall handshake.
// ----------------------------------------------------------------------------
module ecm_cnf_core #(
	parameter int MAX_CLASSES = ecm_cnf_pkg::MAX_CLASSES
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          ecm_byte,
	input  wire logic [15:0]         request_caid,
	input  wire logic                last_byte,
	input  wire ecm_cnf_pkg::cfg_t   cfg,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               verdict,
	output logic                     accepted,
	output logic [7:0]               class_count
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SEARCH,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	function automatic phase_t search_next(input logic [7:0] b);
		phase_t ph;
		if (b == ecm_cnf_pkg::TAG_CLASS) begin
			ph = PH_LENGTH;
		end else if (b == ecm_cnf_pkg::TAG_END) begin
			ph = PH_DONE;
		end else begin
			ph = PH_SEARCH;
		end
		return ph;
	endfunction

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] caid_s1;
	logic        last_s1;

	// message state
	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic        long_q, long_d;
	logic [7:0]  left_q, left_d;
	logic        bseen_q, bseen_d;
	logic        aseen_q, aseen_d;
	logic [7:0]  found_q, found_d;

	logic        out_valid_q;
	logic [1:0]  verdict_q, verdict_d;
	logic        accepted_q;
	logic [7:0]  count_q, count_d;

	logic        advance;
	logic        take;
	logic        unchecked;
	ecm_cnf_pkg::match_t hit;

	ecm_cnf_match #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_match (
		.class_byte (byte_s1),
		.cfg        (cfg),
		.hit        (hit)
	);

	// a final byte waits until the result register is free
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= ecm_byte;
			caid_s1 <= request_caid;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		pos_d   = pos_q;
		long_d  = long_q;
		phase_d = phase_q;
		left_d  = left_q;
		bseen_d = bseen_q;
		aseen_d = aseen_q;
		found_d = found_q;
		take    = 1'b0;

		if (pos_q == ecm_cnf_pkg::POS_LONG_MARK) begin
			long_d = (byte_s1 == ecm_cnf_pkg::LONG_MARK);
		end
		if (pos_q < ecm_cnf_pkg::POS_MAX) begin
			pos_d = pos_q + 4'd1;
		end

		case (phase_q)
			PH_HEADER: begin
				if (pos_q >= (long_d ? ecm_cnf_pkg::START_LONG : ecm_cnf_pkg::START_SHORT)) begin
					phase_d = search_next(byte_s1);
				end
			end
			PH_SEARCH: begin
				phase_d = search_next(byte_s1);
			end
			PH_LENGTH: begin
				// zero length: the length byte is the class
				if (byte_s1 == 8'd0) begin
					take = 1'b1;
				end else begin
					left_d  = byte_s1;
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				left_d = left_q - 8'd1;
				if (left_d == 8'd0) begin
					take = 1'b1;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase

		if (take) begin
			if (hit.blocked) begin
				bseen_d = 1'b1;
				phase_d = PH_DONE;
			end else begin
				if (found_q != ecm_cnf_pkg::COUNT_MAX) begin
					found_d = found_q + 8'd1;
				end
				if (hit.allowed) begin
					aseen_d = 1'b1;
				end
				// the class byte is itself searched
				phase_d = search_next(byte_s1);
			end
		end

		unchecked = (caid_s1 != ecm_cnf_pkg::CAID_FILTERED) ||
			(cfg.blocked_count == 4'd0 && cfg.allowed_count == 4'd0);
		count_d = found_d;
		if (unchecked) begin
			verdict_d = ecm_cnf_pkg::VERDICT_UNCHECKED;
			count_d   = 8'd0;
		end else if (bseen_d) begin
			verdict_d = ecm_cnf_pkg::VERDICT_BLOCKED;
		end else if (found_d != 8'd0 && cfg.allowed_count != 4'd0 && !aseen_d) begin
			verdict_d = ecm_cnf_pkg::VERDICT_NOT_ALLOWED;
		end else begin
			verdict_d = ecm_cnf_pkg::VERDICT_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			long_q      <= 1'b0;
			left_q      <= '0;
			bseen_q     <= 1'b0;
			aseen_q     <= 1'b0;
			found_q     <= '0;
			out_valid_q <= 1'b0;
			verdict_q   <= '0;
			accepted_q  <= 1'b0;
			count_q     <= '0;
		end else begin
			if (advance) begin
				if (last_s1) begin
					phase_q <= PH_HEADER;
					pos_q   <= '0;
					long_q  <= 1'b0;
					left_q  <= '0;
					bseen_q <= 1'b0;
					aseen_q <= 1'b0;
					found_q <= '0;
				end else begin
					phase_q <= phase_d;
					pos_q   <= pos_d;
					long_q  <= long_d;
					left_q  <= left_d;
					bseen_q <= bseen_d;
					aseen_q <= aseen_d;
					found_q <= found_d;
				end
			end
			if (advance && last_s1) begin
				out_valid_q <= 1'b1;
				verdict_q   <= verdict_d;
				accepted_q  <= (verdict_d == ecm_cnf_pkg::VERDICT_UNCHECKED) ||
					(verdict_d == ecm_cnf_pkg::VERDICT_PASS);
				count_q     <= count_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign accepted    = accepted_q;
	assign class_count = count_q;

`ifndef ASSERT_OFF
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid)
		else $error("final byte did not produce a result");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> pos_q == 4'd0 && phase_q == PH_HEADER && found_q == 8'd0)
		else $error("message state not cleared after final byte");

	a_accepted_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> accepted == (verdict == ecm_cnf_pkg::VERDICT_UNCHECKED ||
			verdict == ecm_cnf_pkg::VERDICT_PASS))
		else $error("accepted flag disagrees with verdict");

	a_unchecked_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == ecm_cnf_pkg::VERDICT_UNCHECKED |-> class_count == 8'd0)
		else $error("unchecked verdict with nonzero class count");

	a_blocked_done: assert property (@(posedge clk) disable iff (!arst_n)
		bseen_q |-> phase_q == PH_DONE)
		else $error("search continued after a blocked class");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ecm_class_nano_filter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecm_class_nano_filter_top: ecm class nano filter
// Scans a control message for class nanos and checks each class against
// configurable blocked and allowed lists, giving one verdict per message.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one message byte per item, with the request's
//   system id and a flag on the final byte. An item is taken at a clock edge
//   with in_valid high and in_stall low; one item per cycle is sustained
//   while in_stall stays low. Only the final byte of a message yields an
//   item on the output channel (verdict, accepted, class_count), through
//   the result register: while it sits in the input register the parse
//   state and the class compare settle into the result register.
//   If the receiver stalls, the result holds in its register; further
//   non-final bytes keep flowing, and a final byte waits in the input
//   register until the result slot frees, which back-pressures in_stall.
//   Lists and counts are written through the APB-style port at byte addresses
//   0, 8, 16, 24, by the user only while no message is in flight (unchecked).
//   Reset clears the lists, counts, parse state and both valid flags.
// ----------------------------------------------------------------------------
module ecm_class_nano_filter_top #(
	parameter int MAX_CLASSES = ecm_cnf_pkg::MAX_CLASSES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   ecm_byte,
	input  wire logic [15:0]  request_caid,
	input  wire logic         last_byte,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [1:0]        verdict,
	output logic              accepted,
	output logic [7:0]        class_count
);

	ecm_cnf_pkg::cfg_t cfg;

	ecm_cnf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ecm_cnf_core #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ecm_byte     (ecm_byte),
		.request_caid (request_caid),
		.last_byte    (last_byte),
		.cfg          (cfg),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.verdict      (verdict),
		.accepted     (accepted),
		.class_count  (class_count)
	);

endmodule
`default_nettype wire
